// ----- rtl/stdp_pkg.sv -----
// Shared types, command codes and trace decay helpers for the STDP learning engine.
package stdp_pkg;

  localparam logic [2:0] CMD_PRE    = 3'd0;
  localparam logic [2:0] CMD_POST   = 3'd1;
  localparam logic [2:0] CMD_REWARD = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_EN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_LRN_EN = 2'd3;

  localparam logic [7:0] TRACE_BUMP   = 8'd128;
  localparam logic signed [8:0] ELIG_BUMP = 9'sd32;
  localparam logic signed [8:0] ELIG_MAX  = 9'sd127;

  localparam logic [7:0] DECAY_TABLE [16] = '{
    8'd255, 8'd223, 8'd195, 8'd170, 8'd149, 8'd130, 8'd114, 8'd100,
    8'd87,  8'd76,  8'd67,  8'd58,  8'd51,  8'd45,  8'd39,  8'd34
  };

  typedef struct packed {
    logic [2:0]        cmd;
    logic [5:0]        neuron_index;
    logic [5:0]        column_index;
    logic [15:0]       spike_time;
    logic signed [7:0] reward;
    logic signed [7:0] weight_in;
  } in_t;

  typedef struct packed {
    logic signed [7:0] weight_out;
    logic [7:0]        trace_out;
  } out_t;

  // One neuron's learning state
  typedef struct packed {
    logic [7:0]        pre_tr;
    logic [15:0]       pre_t;
    logic [7:0]        post_tr;
    logic [15:0]       post_t;
    logic signed [7:0] pre_el;
    logic signed [7:0] post_el;
  } nrn_t;

  // Lazily decayed trace; zero once 16 or more ticks have passed
  function automatic logic [7:0] decayed(input logic [7:0] tr, input logic [15:0] dt);
    logic [15:0] prod;
    logic [7:0]  res;
    prod = 16'(tr) * 16'(DECAY_TABLE[dt[3:0]]);
    if (tr == 8'd0 || dt[15:4] != 12'd0) begin
      res = 8'd0;
    end else begin
      res = prod[15:8];
    end
    return res;
  endfunction

  function automatic logic [7:0] bump_trace(input logic [7:0] p);
    logic [8:0] t;
    t = {1'b0, p} + {1'b0, TRACE_BUMP};
    return t[8] ? 8'hFF : t[7:0];
  endfunction

  function automatic logic signed [7:0] bump_elig(input logic signed [7:0] e);
    logic signed [8:0] s;
    s = {e[7], e} + ELIG_BUMP;
    return (s > ELIG_MAX) ? 8'sd127 : s[7:0];
  endfunction

  // e - floor(e/8)
  function automatic logic signed [7:0] decay_elig(input logic signed [7:0] e);
    logic signed [7:0] q;
    q = e >>> 3;
    return e - q;
  endfunction

endpackage

// ----- rtl/stdp_reward_learning_engine_core.sv -----
// Trace-based STDP learning engine with reward modulation: top level.
// A spike walks its partners, one partner per cycle through the weight memory port;
//   a nonzero reward walks the synapses, one synapse per cycle, and any reward then
//   decays the eligibilities, one eligibility pair per cycle. One command at a time.
// Reset: synchronous; a clearing sweep then zeroes 4**clog2(NEURON_COUNT) weight
//   entries, one a cycle (4096 for 64 neurons), with input stalled throughout.
module stdp_reward_learning_engine_core #(
  parameter int NEURON_COUNT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  stdp_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output stdp_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [stdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int IW     = $clog2(NEURON_COUNT);
  localparam int AW     = 2 * IW;
  localparam int WDEPTH = 1 << AW;
  localparam logic [IW-1:0] LAST = IW'(NEURON_COUNT - 1);

  typedef enum logic [11:0] {
    ST_CLEAR     = 12'b0000_0000_0001,
    ST_IDLE      = 12'b0000_0000_0010,
    ST_BUMP_RD   = 12'b0000_0000_0100,
    ST_BUMP_WR   = 12'b0000_0000_1000,
    ST_WALK      = 12'b0000_0001_0000,
    ST_RWALK     = 12'b0000_0010_0000,
    ST_DRAIN     = 12'b0000_0100_0000,
    ST_DECAY     = 12'b0000_1000_0000,
    ST_DECAY_END = 12'b0001_0000_0000,
    ST_RD_ISS    = 12'b0010_0000_0000,
    ST_RD_CAP    = 12'b0100_0000_0000,
    ST_RESP      = 12'b1000_0000_0000
  } st_t;

  st_t state_r, state_nxt;

  // configuration
  logic signed [7:0] min_r, max_r;
  logic              le_r, rle_r;

  // latched command
  logic [2:0]        cmd_r;
  logic [IW-1:0]     n_r, c_r;
  logic [15:0]       now_r;
  logic signed [7:0] rew_r;
  stdp_pkg::out_t    res_r;

  // sweep counters
  logic [IW-1:0] k_r, ri_r, rj_r;
  logic [AW-1:0] clr_r;

  // memories: synapse weights (row = pre, column = post) and per-neuron state
  logic signed [7:0] wmem [WDEPTH];
  stdp_pkg::nrn_t    nmem [NEURON_COUNT];

  logic              w_we;
  logic [AW-1:0]     w_waddr, w_raddr;
  logic signed [7:0] w_wdata, w_rd_r;
  logic              n_we;
  logic [IW-1:0]     n_waddr, na_addr, nb_addr;
  stdp_pkg::nrn_t    n_wdata, na_rd_r, nb_rd_r;

  // update pipeline: stage 1 decayed trace or eligibility product,
  // stage 2 weight step, stage 3 clip and write back
  logic              v1_r, v2_r, v3_r;
  logic [AW-1:0]     a1_r, a2_r, a3_r;
  logic signed [7:0] w2_r, w3_r;
  logic              en2_r, en3_r;
  logic signed [15:0] x2_r;
  logic signed [10:0] d3_r;

  // eligibility decay write-back
  logic          dv_r;
  logic [IW-1:0] da_r;

  logic out_valid_r;
  stdp_pkg::out_t out_data_r;

  logic acc, n_ok, c_ok, is_pre, is_rew, out_free;
  assign acc      = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign n_ok     = int'(in_data.neuron_index) < NEURON_COUNT;
  assign c_ok     = int'(in_data.column_index) < NEURON_COUNT;
  assign is_pre   = (cmd_r == stdp_pkg::CMD_PRE);
  assign is_rew   = (cmd_r == stdp_pkg::CMD_REWARD);
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- own-neuron bump (spike) ----------------
  logic [7:0]        own_tr, own_p, own_new;
  logic [15:0]       own_t;
  logic signed [7:0] own_el;
  stdp_pkg::nrn_t    bump_word;

  always_comb begin
    own_tr  = is_pre ? na_rd_r.pre_tr : na_rd_r.post_tr;
    own_t   = is_pre ? na_rd_r.pre_t  : na_rd_r.post_t;
    own_el  = is_pre ? na_rd_r.pre_el : na_rd_r.post_el;
    own_p   = stdp_pkg::decayed(own_tr, now_r - own_t);
    own_new = stdp_pkg::bump_trace(own_p);
    bump_word = na_rd_r;
    if (is_pre) begin
      bump_word.pre_tr = own_new;
      bump_word.pre_t  = now_r;
      bump_word.pre_el = stdp_pkg::bump_elig(own_el);
    end else begin
      bump_word.post_tr = own_new;
      bump_word.post_t  = now_r;
      bump_word.post_el = stdp_pkg::bump_elig(own_el);
    end
  end

  // ---------------- stage 1 ----------------
  logic [7:0]         s1_tr, s1_p;
  logic [15:0]        s1_t;
  logic signed [15:0] s1_prod;
  logic               s1_en;
  always_comb begin
    s1_tr   = is_pre ? nb_rd_r.post_tr : nb_rd_r.pre_tr;
    s1_t    = is_pre ? nb_rd_r.post_t  : nb_rd_r.pre_t;
    s1_p    = stdp_pkg::decayed(s1_tr, now_r - s1_t);
    s1_prod = na_rd_r.pre_el * nb_rd_r.post_el;
    s1_en   = is_rew ? (na_rd_r.pre_el != 8'sd0 && nb_rd_r.post_el != 8'sd0)
                     : (s1_p != 8'd0);
  end

  // ---------------- stage 2 ----------------
  logic signed [8:0]  s2_diff, s2_p9, s2_mag;
  logic signed [17:0] s2_prod, s2_sh;
  logic [3:0]         s2_shamt;
  logic signed [15:0] s2_rsh;
  logic signed [10:0] s2_delta;
  always_comb begin
    s2_diff = is_pre ? ({w2_r[7], w2_r} - {min_r[7], min_r})
                     : ({max_r[7], max_r} - {w2_r[7], w2_r});
    s2_p9   = signed'({1'b0, x2_r[7:0]});
    s2_prod = s2_diff * s2_p9;
    s2_sh   = s2_prod >>> 8;
    // reward step size picked from reward magnitude
    s2_mag  = (rew_r < 8'sd0) ? -{rew_r[7], rew_r} : {rew_r[7], rew_r};
    if (s2_mag >= 9'sd64) begin
      s2_shamt = 4'd9;
    end else if (s2_mag >= 9'sd32) begin
      s2_shamt = 4'd10;
    end else if (s2_mag >= 9'sd16) begin
      s2_shamt = 4'd11;
    end else begin
      s2_shamt = 4'd12;
    end
    s2_rsh = x2_r >>> s2_shamt;
    if (is_rew) begin
      s2_delta = (rew_r < 8'sd0) ? -11'(s2_rsh) : 11'(s2_rsh);
    end else begin
      s2_delta = is_pre ? -11'(s2_sh) : 11'(s2_sh);
    end
  end

  // ---------------- stage 3: clip ----------------
  logic signed [11:0] s3_sum;
  logic signed [7:0]  s3_w;
  always_comb begin
    s3_sum = {{4{w3_r[7]}}, w3_r} + {d3_r[10], d3_r};
    if (s3_sum > signed'({{4{max_r[7]}}, max_r})) begin
      s3_w = max_r;
    end else if (s3_sum < signed'({{4{min_r[7]}}, min_r})) begin
      s3_w = min_r;
    end else begin
      s3_w = s3_sum[7:0];
    end
  end

  // ---------------- memory port control ----------------
  stdp_pkg::nrn_t dec_word;
  always_comb begin
    dec_word         = na_rd_r;
    dec_word.pre_el  = stdp_pkg::decay_elig(na_rd_r.pre_el);
    dec_word.post_el = stdp_pkg::decay_elig(na_rd_r.post_el);

    case (state_r)
      ST_WALK:  w_raddr = is_pre ? {n_r, k_r} : {k_r, n_r};
      ST_RWALK: w_raddr = {ri_r, rj_r};
      default:  w_raddr = {n_r, c_r};
    endcase

    w_we    = 1'b0;
    w_waddr = a3_r;
    w_wdata = s3_w;
    if (state_r == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_r;
      w_wdata = 8'sd0;
    end else if (acc && in_data.cmd == stdp_pkg::CMD_WRITE && n_ok && c_ok) begin
      w_we    = 1'b1;
      w_waddr = {IW'(in_data.neuron_index), IW'(in_data.column_index)};
      w_wdata = in_data.weight_in;
    end else if (v3_r && en3_r) begin
      w_we = 1'b1;
    end

    case (state_r)
      ST_RWALK: na_addr = ri_r;
      ST_DECAY: na_addr = k_r;
      default:  na_addr = n_r;
    endcase
    nb_addr = (state_r == ST_RWALK) ? rj_r : k_r;

    n_we    = 1'b0;
    n_waddr = n_r;
    n_wdata = bump_word;
    if (state_r == ST_CLEAR) begin
      n_we    = int'(clr_r) < NEURON_COUNT;
      n_waddr = clr_r[IW-1:0];
      n_wdata = '0;
    end else if (state_r == ST_BUMP_WR) begin
      n_we = 1'b1;
    end else if (dv_r) begin
      n_we    = 1'b1;
      n_waddr = da_r;
      n_wdata = dec_word;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rd_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[n_waddr] <= n_wdata;
    end
    na_rd_r <= nmem[na_addr];
    nb_rd_r <= nmem[nb_addr];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_data.cmd)
            stdp_pkg::CMD_PRE, stdp_pkg::CMD_POST:
              state_nxt = (le_r && n_ok) ? ST_BUMP_RD : ST_RESP;
            stdp_pkg::CMD_REWARD: begin
              if (le_r && rle_r) begin
                state_nxt = (in_data.reward != 8'sd0) ? ST_RWALK : ST_DECAY;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            stdp_pkg::CMD_READ:
              state_nxt = (n_ok && c_ok) ? ST_RD_ISS : ST_RESP;
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_BUMP_RD:   state_nxt = ST_BUMP_WR;
      ST_BUMP_WR:   state_nxt = ST_WALK;
      ST_WALK: begin
        if (k_r == LAST) state_nxt = ST_DRAIN;
      end
      ST_RWALK: begin
        if (ri_r == LAST && rj_r == LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) state_nxt = is_rew ? ST_DECAY : ST_RESP;
      end
      ST_DECAY: begin
        if (k_r == LAST) state_nxt = ST_DECAY_END;
      end
      ST_DECAY_END: state_nxt = ST_RESP;
      ST_RD_ISS:    state_nxt = ST_RD_CAP;
      ST_RD_CAP:    state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      min_r       <= 8'sd0;
      max_r       <= 8'sd127;
      le_r        <= 1'b0;
      rle_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ri_r        <= '0;
      rj_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;

      if (cfg_we) begin
        case (cfg_index)
          stdp_pkg::CFG_MIN_WEIGHT:    min_r <= cfg_data;
          stdp_pkg::CFG_MAX_WEIGHT:    max_r <= cfg_data;
          stdp_pkg::CFG_LEARN_EN:      le_r  <= cfg_data[0];
          stdp_pkg::CFG_REWARD_LRN_EN: rle_r <= cfg_data[0];
          default: ;
        endcase
      end

      v1_r <= (state_r == ST_WALK) || (state_r == ST_RWALK);
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r <= (state_r == ST_DECAY);

      if (acc) begin
        k_r  <= '0;
        ri_r <= '0;
        rj_r <= '0;
      end else if (state_r == ST_WALK || state_r == ST_DECAY) begin
        k_r <= k_r + 1'b1;
      end else if (state_r == ST_RWALK) begin
        if (rj_r == LAST) begin
          rj_r <= '0;
          ri_r <= ri_r + 1'b1;
        end else begin
          rj_r <= rj_r + 1'b1;
        end
      end

      // result register: loaded when the command ends, freed by the transfer
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_data.cmd;
      n_r   <= IW'(in_data.neuron_index);
      c_r   <= IW'(in_data.column_index);
      now_r <= in_data.spike_time;
      rew_r <= in_data.reward;
      res_r <= '0;
    end else if (state_r == ST_BUMP_WR) begin
      res_r.trace_out <= own_new;
    end else if (state_r == ST_RD_CAP) begin
      res_r.weight_out <= w_rd_r;
    end

    if (state_r == ST_RESP && out_free) out_data_r <= res_r;

    a1_r  <= w_raddr;
    a2_r  <= a1_r;
    w2_r  <= w_rd_r;
    x2_r  <= is_rew ? s1_prod : signed'({8'd0, s1_p});
    en2_r <= s1_en;
    a3_r  <= a2_r;
    w3_r  <= w2_r;
    en3_r <= en2_r;
    d3_r  <= s2_delta;
    da_r  <= k_r;
  end

endmodule
